>>> sv/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the connection slot tracker
// Slot record, command and result beats, function, config, status and outcome codes, FSM states.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int unsigned SLOTS_DEF   = 16;
    localparam int unsigned GEN_W       = 16;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned TIME_W      = 63;
    localparam int unsigned TIMEOUT_W   = 40;
    localparam int unsigned LIMIT_W     = 5;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 40;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 40'd4000000000;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 5'd4;

    typedef enum logic [1:0] {
        FN_OPEN  = 2'd0,
        FN_COMP  = 2'd1,
        FN_PRUNE = 2'd2,
        FN_CLOSE = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_LIMIT   = 2'd1
    } t_cfg_idx;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SOCK_FAILED = 2'd1;

    typedef enum logic [3:0] {
        OC_ACCEPTED  = 4'd0,
        OC_REJECTED  = 4'd1,
        OC_DROPPED   = 4'd2,
        OC_FAILED    = 4'd3,
        OC_EVICTED   = 4'd4,
        OC_CONNECTED = 4'd5,
        OC_TIMED_OUT = 4'd6,
        OC_STALE     = 4'd7,
        OC_DONE      = 4'd8
    } t_outcome;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] peer_address;
        logic [TIME_W-1:0] now_time;
        logic [31:0]       event_id;
        logic [1:0]        open_status;
        logic              completion_error;
    } t_in;

    typedef struct packed {
        logic [3:0]        outcome;
        logic [31:0]       result_id;
        logic [ADDR_W-1:0] slot_address;
        logic [4:0]        live_count;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              valid;
        logic [GEN_W-1:0]  gen;
        logic [ADDR_W-1:0] peer;
        logic [TIME_W-1:0] deadline;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_OPEN_DEC,
        S_OPEN_ST,
        S_COMP_DEC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        P_OPEN,
        P_COMP,
        P_PRUNE,
        P_WRITE
    } t_pass;

endpackage

>>> sv/cst_cell.sv
// ----------------------------------------------------------------------------
// cst_cell: one slot of the rotating slot ring
// Holds a slot record and takes its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module cst_cell import cst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_d,
    output t_slot o_q
);

    t_slot r_slot;

    // whole slot record resets to zero and shifts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_d;
        end
    end

    assign o_q = r_slot;

endmodule

>>> sv/connection_slot_tracker_top.sv
// ----------------------------------------------------------------------------
// connection_slot_tracker_top: connection slot table on a rotating cell ring
// Open, completion, prune and close-all commands over a ring of slot cells.
// ----------------------------------------------------------------------------
// The first result comes in the cycle after the decision that makes it.
// One command at a time; each pass walks the ring once, one slot per cycle.
// Results come one per cycle on o_strobe and cannot be stalled.
// Synchronous active-low reset clears the table, generations and live count.
// ----------------------------------------------------------------------------
module connection_slot_tracker_top import cst_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    output logic                  o_strobe,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // ring of cells
    t_slot w_q [SLOTS];
    t_slot n_head;
    t_slot head;
    logic  w_shift;

    assign head = w_q[0];

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_slot w_d;
        if (k == SLOTS - 1) begin : g_tail
            assign w_d = n_head;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        cst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    // control registers
    t_state              r_state, n_state;
    t_pass               r_pass, n_pass;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_live, n_live;
    logic                r_strobe, n_strobe;
    logic                r_kill, n_kill;
    logic                r_claim, n_claim;
    logic                r_clear, n_clear;
    logic                r_free_found, n_free_found;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [LIMIT_W-1:0]  r_limit;

    // payload registers
    t_in                 r_in, n_in;
    t_out                r_out, n_out;
    logic [TIME_W-1:0]   r_deadline, n_deadline;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [TIME_W-1:0]   r_min_dl, n_min_dl;
    logic [IDX_W-1:0]    r_pick, n_pick;
    logic [GEN_W-1:0]    r_pgen, n_pgen;
    logic [ADDR_W-1:0]   r_ppeer, n_ppeer;
    logic [IDX_W-1:0]    r_free, n_free;
    logic [GEN_W-1:0]    r_fgen, n_fgen;
    logic                r_cv, n_cv;
    logic [GEN_W-1:0]    r_cgen, n_cgen;
    logic [ADDR_W-1:0]   r_cpeer, n_cpeer;
    logic [IDX_W-1:0]    r_target, n_target;
    logic [GEN_W-1:0]    r_tgen, n_tgen;

    logic [TIME_W:0]     w_sum;
    logic                w_pass_end;
    logic                w_eid_ok;
    logic [15:0]         w_idx16;
    logic [GEN_W-1:0]    w_tgen_inc;

    assign w_sum      = {1'b0, i_item.now_time} + {{(TIME_W+1-TIMEOUT_W){1'b0}}, r_timeout};
    assign w_pass_end = (r_idx == IDX_LAST);
    assign w_eid_ok   = (r_in.event_id[15:0] < 16'(SLOTS));
    assign w_idx16    = {{(16-IDX_W){1'b0}}, r_idx};
    assign w_tgen_inc = r_tgen + 1'b1;
    assign w_shift    = (r_state == S_PASS);

    // next state, ring head update and result beats
    always_comb begin
        n_state      = r_state;
        n_pass       = r_pass;
        n_idx        = r_idx;
        n_live       = r_live;
        n_strobe     = 1'b0;
        n_kill       = r_kill;
        n_claim      = r_claim;
        n_clear      = r_clear;
        n_free_found = r_free_found;
        n_in         = r_in;
        n_out        = r_out;
        n_deadline   = r_deadline;
        n_cnt        = r_cnt;
        n_min_dl     = r_min_dl;
        n_pick       = r_pick;
        n_pgen       = r_pgen;
        n_ppeer      = r_ppeer;
        n_free       = r_free;
        n_fgen       = r_fgen;
        n_cv         = r_cv;
        n_cgen       = r_cgen;
        n_cpeer      = r_cpeer;
        n_target     = r_target;
        n_tgen       = r_tgen;
        n_head       = head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in         = i_item;
                    n_deadline   = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_free_found = 1'b0;
                    n_kill       = 1'b0;
                    n_claim      = 1'b0;
                    n_clear      = 1'b0;
                    n_state      = S_PASS;
                    unique case (t_func'(i_item.func))
                        FN_OPEN:  n_pass = P_OPEN;
                        FN_COMP:  n_pass = P_COMP;
                        FN_PRUNE: n_pass = P_PRUNE;
                        FN_CLOSE: begin
                            n_pass   = P_WRITE;
                            n_clear  = 1'b1;
                            n_live   = '0;
                            n_strobe = 1'b1;
                            n_out    = '{outcome: OC_DONE, result_id: '0, slot_address: '0,
                                         live_count: '0, last: 1'b1};
                        end
                        default: n_pass = P_WRITE;
                    endcase
                end
            end

            S_PASS: begin
                n_idx = w_pass_end ? '0 : r_idx + 1'b1;
                unique case (r_pass)
                    P_OPEN: begin
                        if (head.valid && head.peer == r_in.peer_address) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        if (r_idx == '0 || head.deadline < r_min_dl) begin
                            n_min_dl = head.deadline;
                            n_pick   = r_idx;
                            n_pgen   = head.gen;
                            n_ppeer  = head.peer;
                        end
                        if (!head.valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free       = r_idx;
                            n_fgen       = head.gen;
                        end
                        if (w_pass_end) begin
                            n_state = S_OPEN_DEC;
                        end
                    end
                    P_COMP: begin
                        if (r_idx == r_in.event_id[IDX_W-1:0]) begin
                            n_cv    = head.valid;
                            n_cgen  = head.gen;
                            n_cpeer = head.peer;
                        end
                        if (w_pass_end) begin
                            n_state = S_COMP_DEC;
                        end
                    end
                    P_PRUNE: begin
                        // expired slot leaves and reports
                        if (head.valid && r_in.now_time >= head.deadline) begin
                            n_head.valid = 1'b0;
                            n_live       = r_live - 1'b1;
                            n_strobe     = 1'b1;
                            n_out        = '{outcome: OC_TIMED_OUT,
                                             result_id: {head.gen, w_idx16},
                                             slot_address: head.peer,
                                             live_count: 5'(r_live - 1'b1), last: 1'b0};
                        end
                        if (w_pass_end) begin
                            n_state = S_DONE;
                        end
                    end
                    P_WRITE: begin
                        if (r_clear) begin
                            n_head.valid = 1'b0;
                        end else if (r_idx == r_target) begin
                            if (r_claim) begin
                                n_head.valid    = 1'b1;
                                n_head.gen      = head.gen + 1'b1;
                                n_head.peer     = r_in.peer_address;
                                n_head.deadline = r_deadline;
                            end else if (r_kill) begin
                                n_head.valid = 1'b0;
                            end
                        end
                        if (w_pass_end) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_OPEN_DEC: begin
                if ({{(CNT_W < LIMIT_W ? LIMIT_W-CNT_W : 0){1'b0}}, r_cnt} >=
                    {{(LIMIT_W < CNT_W ? CNT_W-LIMIT_W : 0){1'b0}}, r_limit}) begin
                    n_strobe = 1'b1;
                    n_out    = '{outcome: OC_REJECTED, result_id: '0,
                                 slot_address: r_in.peer_address,
                                 live_count: 5'(r_live), last: 1'b1};
                    n_state  = S_IDLE;
                end else if (r_live == CNT_W'(SLOTS)) begin
                    // table full: earliest deadline goes
                    n_kill   = 1'b1;
                    n_target = r_pick;
                    n_tgen   = r_pgen;
                    n_live   = r_live - 1'b1;
                    n_strobe = 1'b1;
                    n_out    = '{outcome: OC_EVICTED,
                                 result_id: {r_pgen, {{(16-IDX_W){1'b0}}, r_pick}},
                                 slot_address: r_ppeer,
                                 live_count: 5'(r_live - 1'b1), last: 1'b0};
                    n_state  = S_OPEN_ST;
                end else begin
                    n_target = r_free;
                    n_tgen   = r_fgen;
                    n_state  = S_OPEN_ST;
                end
            end

            S_OPEN_ST: begin
                n_strobe = 1'b1;
                if (r_in.open_status != ST_OK) begin
                    n_out   = '{outcome: (r_in.open_status == ST_SOCK_FAILED) ?
                                         OC_DROPPED : OC_FAILED,
                                result_id: '0, slot_address: r_in.peer_address,
                                live_count: 5'(r_live), last: 1'b1};
                    n_state = r_kill ? S_PASS : S_IDLE;
                    n_pass  = P_WRITE;
                end else begin
                    n_claim = 1'b1;
                    n_live  = r_live + 1'b1;
                    n_out   = '{outcome: OC_ACCEPTED,
                                result_id: {w_tgen_inc, {{(16-IDX_W){1'b0}}, r_target}},
                                slot_address: r_in.peer_address,
                                live_count: 5'(r_live + 1'b1), last: 1'b1};
                    n_state = S_PASS;
                    n_pass  = P_WRITE;
                end
            end

            S_COMP_DEC: begin
                n_strobe = 1'b1;
                if (!w_eid_ok || !r_cv || r_cgen != r_in.event_id[31:16]) begin
                    n_out   = '{outcome: OC_STALE, result_id: r_in.event_id,
                                slot_address: '0, live_count: 5'(r_live), last: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_kill   = 1'b1;
                    n_target = r_in.event_id[IDX_W-1:0];
                    n_live   = r_live - 1'b1;
                    n_out    = '{outcome: r_in.completion_error ? OC_FAILED : OC_CONNECTED,
                                 result_id: r_in.event_id, slot_address: r_cpeer,
                                 live_count: 5'(r_live - 1'b1), last: 1'b1};
                    n_state  = S_PASS;
                    n_pass   = P_WRITE;
                end
            end

            S_DONE: begin
                n_strobe = 1'b1;
                n_out    = '{outcome: OC_DONE, result_id: '0, slot_address: '0,
                             live_count: 5'(r_live), last: 1'b1};
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pass       <= P_WRITE;
            r_idx        <= '0;
            r_live       <= '0;
            r_strobe     <= 1'b0;
            r_kill       <= 1'b0;
            r_claim      <= 1'b0;
            r_clear      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pass       <= n_pass;
            r_idx        <= n_idx;
            r_live       <= n_live;
            r_strobe     <= n_strobe;
            r_kill       <= n_kill;
            r_claim      <= n_claim;
            r_clear      <= n_clear;
            r_free_found <= n_free_found;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
            end else if (i_cfg_idx == CFG_LIMIT) begin
                r_limit <= i_cfg_data[LIMIT_W-1:0];
            end
        end
    end

    // command and scan payload
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_out      <= n_out;
        r_deadline <= n_deadline;
        r_cnt      <= n_cnt;
        r_min_dl   <= n_min_dl;
        r_pick     <= n_pick;
        r_pgen     <= n_pgen;
        r_ppeer    <= n_ppeer;
        r_free     <= n_free;
        r_fgen     <= n_fgen;
        r_cv       <= n_cv;
        r_cgen     <= n_cgen;
        r_cpeer    <= n_cpeer;
        r_target   <= n_target;
        r_tgen     <= n_tgen;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // a result that is not the final one means the command is still running
    a_mid_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out.last) |-> busy)
        else $error("non-final result beat while idle");

    // live count never exceeds the table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOTS))
        else $error("live count above slot count");

    // the ring is back in slot order whenever the block is idle
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_idx == '0))
        else $error("ring position not home while idle");

    // an accepted command makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the connection slot tracker
// Drives a short table of directed commands, then random open, completion,
// prune and close-all traffic over several register settings and idle
// patterns. Every result beat is compared field by field with a slot-table
// predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top import cst_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NSLOT      = 16;
    localparam int          QUIET_MAX  = 5000;
    localparam int          SETTLE     = 2 * NSLOT + 8;
    localparam logic [62:0] TICK_MAX   = {63{1'b1}};
    localparam logic [1:0]  ST_CONN_FAILED = 2'd2;
    localparam logic [1:0]  ST_UNKNOWN     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_item;
    logic                  o_strobe;
    t_out                  o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    connection_slot_tracker_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted slot table and registers
    logic [39:0] pr_timeout;
    logic [4:0]  pr_limit;
    logic        tab_live [NSLOT];
    logic [31:0] tab_peer [NSLOT];
    logic [62:0] tab_due  [NSLOT];
    logic [15:0] tab_gen  [NSLOT];
    int unsigned live_n;

    t_out        pending_q[$];
    int          errors;
    int          quiet;
    int          idle_pct;
    logic [62:0] clock_ticks;
    logic [31:0] addr_pool [8];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out beat(t_outcome oc, logic [31:0] id, logic [31:0] addr);
        t_out r;
        r.outcome      = oc;
        r.result_id    = id;
        r.slot_address = addr;
        r.live_count   = live_n[4:0];
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] conn_id(int i);
        return {tab_gen[i], 16'(i)};
    endfunction

    function automatic void drop_slot(int i);
        tab_live[i] = 1'b0;
        if (live_n > 0)
            live_n--;
    endfunction

    // work out the result beats of one accepted command
    function automatic void predict_beats(t_in it);
        int          same;
        int          pick;
        logic [62:0] now;
        logic [15:0] idx;
        now = it.now_time;
        case (t_func'(it.func))
            FN_OPEN: begin
                same = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (tab_live[i] && tab_peer[i] == it.peer_address)
                        same++;
                if (same >= pr_limit) begin
                    pending_q.push_back(beat(OC_REJECTED, '0, it.peer_address));
                end else begin
                    // full table: earliest deadline goes, lowest index on a tie
                    if (live_n >= NSLOT) begin
                        pick = 0;
                        for (int i = 1; i < NSLOT; i++)
                            if (tab_due[i] < tab_due[pick])
                                pick = i;
                        drop_slot(pick);
                        pending_q.push_back(beat(OC_EVICTED, conn_id(pick), tab_peer[pick]));
                    end
                    if (it.open_status == ST_SOCK_FAILED) begin
                        pending_q.push_back(beat(OC_DROPPED, '0, it.peer_address));
                    end else if (it.open_status != ST_OK) begin
                        pending_q.push_back(beat(OC_FAILED, '0, it.peer_address));
                    end else begin
                        pick = NSLOT;
                        for (int i = NSLOT - 1; i >= 0; i--)
                            if (!tab_live[i])
                                pick = i;
                        if (pick == NSLOT) begin
                            pending_q.push_back(beat(OC_DROPPED, '0, it.peer_address));
                        end else begin
                            tab_gen[pick]  = tab_gen[pick] + 16'd1;
                            tab_live[pick] = 1'b1;
                            tab_peer[pick] = it.peer_address;
                            tab_due[pick]  = (now > TICK_MAX - 63'(pr_timeout)) ?
                                             TICK_MAX : now + 63'(pr_timeout);
                            live_n++;
                            pending_q.push_back(beat(OC_ACCEPTED, conn_id(pick),
                                                     it.peer_address));
                        end
                    end
                end
            end
            FN_COMP: begin
                idx = it.event_id[15:0];
                if (idx >= NSLOT || !tab_live[idx] || tab_gen[idx] != it.event_id[31:16]) begin
                    pending_q.push_back(beat(OC_STALE, it.event_id, '0));
                end else begin
                    drop_slot(idx);
                    pending_q.push_back(beat(it.completion_error ? OC_FAILED : OC_CONNECTED,
                                             it.event_id, tab_peer[idx]));
                end
            end
            FN_PRUNE: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tab_live[i] && now >= tab_due[i]) begin
                        drop_slot(i);
                        pending_q.push_back(beat(OC_TIMED_OUT, conn_id(i), tab_peer[i]));
                    end
                pending_q.push_back(beat(OC_DONE, '0, '0));
            end
            default: begin
                for (int i = 0; i < NSLOT; i++)
                    tab_live[i] = 1'b0;
                live_n = 0;
                pending_q.push_back(beat(OC_DONE, '0, '0));
            end
        endcase
        pending_q[$].last = 1'b1;
    endfunction

    // one command beat; sender idles at random first
    task automatic send_cmd(t_in it, bit typed, t_out want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_beats(it);
        if (typed) begin
            void'(pending_q.pop_back());
            pending_q.push_back(want);
        end
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        start <= 1'b0;
        while (pending_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_TIMEOUT)
            pr_timeout = val[39:0];
        else if (idx == CFG_LIMIT)
            pr_limit = val[4:0];
    endtask

    function automatic t_in mk(t_func f, logic [31:0] addr, logic [62:0] now,
                               logic [31:0] id, logic [1:0] st, logic err);
        t_in it;
        it.func             = f;
        it.peer_address     = addr;
        it.now_time         = now;
        it.event_id         = id;
        it.open_status      = st;
        it.completion_error = err;
        return it;
    endfunction

    function automatic t_out res(t_outcome oc, logic [31:0] id, logic [31:0] addr,
                                 logic [4:0] live);
        t_out r;
        r.outcome      = oc;
        r.result_id    = id;
        r.slot_address = addr;
        r.live_count   = live;
        r.last         = 1'b1;
        return r;
    endfunction

    // random command with mostly well-formed content
    function automatic t_in rand_cmd();
        t_in         it;
        int          roll;
        int          live_idx[$];
        logic [31:0] id;
        roll = $urandom_range(99);
        clock_ticks = clock_ticks + 63'($urandom_range(3));
        it.peer_address     = ($urandom_range(3) == 0) ? $urandom : addr_pool[$urandom_range(7)];
        it.now_time         = ($urandom_range(19) == 0) ? 63'({$urandom, $urandom}) :
                                                          clock_ticks;
        it.event_id         = $urandom;
        it.open_status      = ($urandom_range(9) < 7) ? ST_OK : 2'($urandom_range(3));
        it.completion_error = 1'($urandom_range(1));
        if (roll < 58) begin
            it.func = FN_OPEN;
        end else if (roll < 88) begin
            it.func = FN_COMP;
            for (int i = 0; i < NSLOT; i++)
                if (tab_live[i])
                    live_idx.push_back(i);
            if (live_idx.size() != 0 && $urandom_range(4) != 0) begin
                id = conn_id(live_idx[$urandom_range(live_idx.size() - 1)]);
                it.event_id = id;
            end
        end else if (roll < 97) begin
            it.func = FN_PRUNE;
        end else begin
            it.func = FN_CLOSE;
        end
        return it;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: outcome %0d id %h addr %h live %0d last %0b",
                             o_result.outcome, o_result.result_id, o_result.slot_address,
                             o_result.live_count, o_result.last);
            end else begin
                if (o_result !== pending_q[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display({"result beat differs: exp outcome %0d id %h addr %h live %0d",
                                  " last %0b / got outcome %0d id %h addr %h live %0d last %0b"},
                                 pending_q[0].outcome, pending_q[0].result_id,
                                 pending_q[0].slot_address, pending_q[0].live_count,
                                 pending_q[0].last, o_result.outcome, o_result.result_id,
                                 o_result.slot_address, o_result.live_count, o_result.last);
                end
                void'(pending_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("connection_slot_tracker_top: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out want;
    } t_row;

    initial begin
        t_row rows[$];
        int   phase_items [5];
        int   phase_idle  [5];
        idle_pct    = 0;
        clock_ticks = '0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        pr_timeout  = TIMEOUT_RST;
        pr_limit    = LIMIT_RST;
        live_n      = 0;
        for (int i = 0; i < NSLOT; i++) begin
            tab_live[i] = 1'b0;
            tab_peer[i] = '0;
            tab_due[i]  = '0;
            tab_gen[i]  = '0;
        end
        addr_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002,
                      32'hC0A8_0101, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: limit, status codes, saturation, stale ids, prune, close
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, '0, '0, ST_OK, 0), 1,
                         res(OC_ACCEPTED, 32'h0001_0000, 32'hFFFF_FFFF, 5'd1)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, TICK_MAX, '0, ST_OK, 0), 1,
                         res(OC_ACCEPTED, 32'h0001_0001, 32'hFFFF_FFFF, 5'd2)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, '0, '0, ST_SOCK_FAILED, 0), 1,
                         res(OC_DROPPED, '0, 32'hFFFF_FFFF, 5'd2)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, '0, '0, ST_CONN_FAILED, 0), 1,
                         res(OC_FAILED, '0, 32'hFFFF_FFFF, 5'd2)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, '0, '0, ST_UNKNOWN, 0), 1,
                         res(OC_FAILED, '0, 32'hFFFF_FFFF, 5'd2)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, 63'd5, '0, ST_OK, 0), 1,
                         res(OC_ACCEPTED, 32'h0001_0002, 32'hFFFF_FFFF, 5'd3)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, 63'd5, '0, ST_OK, 0), 1,
                         res(OC_ACCEPTED, 32'h0001_0003, 32'hFFFF_FFFF, 5'd4)});
        rows.push_back('{mk(FN_OPEN, 32'hFFFF_FFFF, '0, '0, ST_OK, 0), 1,
                         res(OC_REJECTED, '0, 32'hFFFF_FFFF, 5'd4)});
        rows.push_back('{mk(FN_COMP, '0, '0, 32'h0001_0000, ST_OK, 0), 1,
                         res(OC_CONNECTED, 32'h0001_0000, 32'hFFFF_FFFF, 5'd3)});
        rows.push_back('{mk(FN_COMP, '0, '0, 32'h0001_0000, ST_OK, 0), 1,
                         res(OC_STALE, 32'h0001_0000, '0, 5'd3)});
        rows.push_back('{mk(FN_COMP, '0, '0, 32'h0001_0010, ST_OK, 0), 1,
                         res(OC_STALE, 32'h0001_0010, '0, 5'd3)});
        rows.push_back('{mk(FN_COMP, '0, '0, 32'hFFFF_0001, ST_OK, 1), 1,
                         res(OC_STALE, 32'hFFFF_0001, '0, 5'd3)});
        rows.push_back('{mk(FN_COMP, '0, '0, 32'h0001_0001, ST_OK, 1), 1,
                         res(OC_FAILED, 32'h0001_0001, 32'hFFFF_FFFF, 5'd2)});
        rows.push_back('{mk(FN_OPEN, '0, 63'd7, '0, ST_OK, 0), 1,
                         res(OC_ACCEPTED, 32'h0002_0000, '0, 5'd3)});
        rows.push_back('{mk(FN_PRUNE, '0, '0, '0, ST_OK, 0), 1,
                         res(OC_DONE, '0, '0, 5'd3)});
        rows.push_back('{mk(FN_PRUNE, '1, TICK_MAX, '1, ST_UNKNOWN, 1), 0, '0});
        rows.push_back('{mk(FN_OPEN, 32'h1234_5678, 63'd9, '0, ST_OK, 0), 0, '0});
        rows.push_back('{mk(FN_CLOSE, '0, '0, '0, ST_OK, 0), 1,
                         res(OC_DONE, '0, '0, 5'd0)});
        rows.push_back('{mk(FN_OPEN, 32'h1234_5678, 63'd9, '0, ST_OK, 0), 0, '0});
        foreach (rows[r])
            send_cmd(rows[r].cmd, rows[r].typed, rows[r].want);

        // random phases over register settings and idle patterns
        phase_items = '{70, 80, 80, 20, 70};
        phase_idle  = '{0, 64, 19, 0, 64};
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_TIMEOUT, 40'd40);
                end
                1: begin
                    write_reg(CFG_TIMEOUT, 40'd1);
                    write_reg(CFG_LIMIT, 40'd1);
                end
                2: begin
                    write_reg(CFG_TIMEOUT, {40{1'b1}});
                    write_reg(CFG_LIMIT, 40'd16);
                end
                3: begin
                    write_reg(CFG_LIMIT, 40'd0);
                    write_reg(CFG_SPARE_A, {40{1'b1}});
                end
                default: begin
                    write_reg(CFG_TIMEOUT, 40'd100);
                    write_reg(CFG_LIMIT, 40'd31);
                    write_reg(CFG_SPARE_B, 40'd2);
                end
            endcase
            idle_pct = phase_idle[p];
            for (int k = 0; k < phase_items[p]; k++)
                send_cmd(rand_cmd(), 0, '0);
        end
        start <= 1'b0;

        // drain
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("connection_slot_tracker_top: match");
        else
            $display("connection_slot_tracker_top: mismatch");
        $finish;
    end

endmodule
